FILE: rtl/core/midi_pkg.sv
// shared types, codes and helpers for the midi byte stream parser
// no dependencies; imported by midi_byte_stream_parser_unit
package midi_pkg;

  // result kinds
  localparam logic [2:0] KIND_NONE     = 3'd0;
  localparam logic [2:0] KIND_CHANNEL  = 3'd1;
  localparam logic [2:0] KIND_SX_START = 3'd2;
  localparam logic [2:0] KIND_SX_BYTE  = 3'd3;
  localparam logic [2:0] KIND_SX_END   = 3'd4;
  localparam logic [2:0] KIND_OVERFLOW = 3'd5;

  // note classification
  localparam logic [1:0] NOTE_NONE = 2'd0;
  localparam logic [1:0] NOTE_ON   = 2'd1;
  localparam logic [1:0] NOTE_OFF  = 2'd2;

  // special bytes and status groups
  localparam logic [7:0] BYTE_REALTIME = 8'hF8;
  localparam logic [7:0] BYTE_SX_OPEN  = 8'hF0;
  localparam logic [7:0] BYTE_SX_CLOSE = 8'hF7;
  localparam logic [3:0] GRP_NOTE_OFF  = 4'h8;
  localparam logic [3:0] GRP_NOTE_ON   = 4'h9;
  localparam logic [3:0] GRP_POLY_AT   = 4'hA;
  localparam logic [3:0] GRP_CTRL      = 4'hB;
  localparam logic [3:0] GRP_PROGRAM   = 4'hC;
  localparam logic [3:0] GRP_CHAN_AT   = 4'hD;
  localparam logic [3:0] GRP_BEND      = 4'hE;

  // register indexes
  localparam logic REG_DELEGATED = 1'b0;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] msg_status;
    logic [6:0] msg_data1;
    logic [6:0] msg_data2;
    logic [1:0] note_action;
    logic [7:0] sysex_byte;
    logic [8:0] sysex_length;
  } result_t;

  // data bytes a status byte calls for
  function automatic logic [1:0] data_needed_for(input logic [7:0] st);
    logic [1:0] n;
    unique case (st[7:4])
      GRP_NOTE_OFF, GRP_NOTE_ON, GRP_POLY_AT, GRP_CTRL, GRP_BEND: n = 2'd2;
      GRP_PROGRAM, GRP_CHAN_AT: n = 2'd1;
      default: n = 2'd0;
    endcase
    return n;
  endfunction

endpackage

FILE: rtl/core/midi_byte_stream_parser_unit.sv
// midi byte stream parser: running status, channel messages and sysex framing
// depends on midi_pkg (codes, result struct, data count helper)
// each accepted beat's result is registered, in the skid while the output stalls
// throughput: one byte per cycle; a one-entry skid register keeps input open
//   while a result beat is stalled, in_stall rises only when the skid is full
// reset: synchronous, clears parser state, delegated_mode and both output stages
module midi_byte_stream_parser_unit
  import midi_pkg::*;
#(
  parameter int SYSEX_MAX = 256
) (
  input  logic        clk,
  input  logic        rst,
  // byte input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  kind,
  output logic [7:0]  msg_status,
  output logic [6:0]  msg_data1,
  output logic [6:0]  msg_data2,
  output logic [1:0]  note_action,
  output logic [7:0]  sysex_byte,
  output logic [8:0]  sysex_length,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // sysex counter has to hold the limit itself
  localparam int CW = $clog2(SYSEX_MAX + 1);
  // widened copy so the 9-bit length port is a plain slice at any limit
  localparam int LW = (CW > 9) ? CW : 9;
  localparam logic [CW-1:0] SX_LIMIT = CW'(SYSEX_MAX);

  // ---------------------------------------------------------------------------
  // register port: single register, delegated_mode, at byte address 0
  // ---------------------------------------------------------------------------
  logic delegated_mode;
  logic reg_index;

  assign pready    = 1'b1;
  assign reg_index = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      delegated_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready && reg_index == REG_DELEGATED) begin
      delegated_mode <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_index == REG_DELEGATED) begin
      prdata[0] = delegated_mode;
    end
  end

  // ---------------------------------------------------------------------------
  // parser state
  // ---------------------------------------------------------------------------
  logic          in_sysex, in_sysex_next;
  logic [7:0]    current_status, current_status_next;
  logic [7:0]    running_status, running_status_next;
  logic [1:0]    data_count, data_count_next;
  logic [1:0]    data_needed, data_needed_next;
  logic [6:0]    first_data, first_data_next;
  logic [CW-1:0] sysex_count, sysex_count_next;

  logic    accept;
  result_t res;

  assign accept = in_valid && !in_stall;

  // one pass of the parser over the incoming beat
  always_comb begin
    logic [CW-1:0] cnt;
    logic [CW-1:0] cnt_inc;
    logic [LW-1:0] len_wide;
    logic [6:0]    v;
    logic [6:0]    a2;

    in_sysex_next       = in_sysex;
    current_status_next = current_status;
    running_status_next = running_status;
    data_count_next     = data_count;
    data_needed_next    = data_needed;
    first_data_next     = first_data;
    sysex_count_next    = sysex_count;
    res                 = '0;
    cnt                 = '0;
    cnt_inc             = '0;
    len_wide            = '0;
    v                   = in_byte[6:0];
    a2                  = '0;

    priority if (in_byte >= BYTE_REALTIME) begin
      // real-time bytes pass through the parser untouched
    end else if (in_sysex) begin
      // reopening inside a sysex restarts the count
      cnt = (in_byte == BYTE_SX_OPEN) ? '0 : sysex_count;
      if (cnt >= SX_LIMIT) begin
        // buffer full: drop the byte and return to idle
        len_wide             = LW'(cnt);
        res.kind             = KIND_OVERFLOW;
        res.sysex_length     = len_wide[8:0];
        in_sysex_next        = 1'b0;
        current_status_next  = '0;
        running_status_next  = '0;
        data_count_next      = '0;
        data_needed_next     = '0;
        first_data_next      = '0;
        sysex_count_next     = '0;
      end else begin
        cnt_inc          = cnt + CW'(1);
        len_wide         = LW'(cnt_inc);
        res.sysex_byte   = in_byte;
        res.sysex_length = len_wide[8:0];
        sysex_count_next = cnt_inc;
        if (in_byte == BYTE_SX_CLOSE) begin
          // end of sysex also loses running status
          res.kind            = KIND_SX_END;
          in_sysex_next       = 1'b0;
          current_status_next = '0;
          running_status_next = '0;
          data_count_next     = '0;
          data_needed_next    = '0;
          first_data_next     = '0;
          sysex_count_next    = '0;
        end else begin
          res.kind = (in_byte == BYTE_SX_OPEN) ? KIND_SX_START : KIND_SX_BYTE;
        end
      end
    end else if (in_byte == BYTE_SX_OPEN) begin
      res.kind            = KIND_SX_START;
      res.sysex_byte      = in_byte;
      res.sysex_length    = 9'd1;
      in_sysex_next       = 1'b1;
      current_status_next = '0;
      running_status_next = '0;
      data_count_next     = '0;
      data_needed_next    = '0;
      first_data_next     = '0;
      sysex_count_next    = CW'(1);
    end else if (in_byte[7]) begin
      // status byte: system common clears running status
      current_status_next = in_byte;
      data_count_next     = '0;
      data_needed_next    = data_needed_for(in_byte);
      running_status_next = (data_needed_for(in_byte) != 2'd0) ? in_byte : '0;
    end else if (data_needed == 2'd0 && running_status == '0) begin
      // stray data byte with no status to attach to
    end else begin
      if (data_needed == 2'd0) begin
        // rearm from running status
        current_status_next = running_status;
        data_needed_next    = data_needed_for(running_status);
        data_count_next     = '0;
      end
      if (data_count_next == 2'd0) begin
        first_data_next = v;
      end
      if (data_count_next < 2'd2) begin
        data_count_next = data_count_next + 2'd1;
      end
      if (data_count_next >= data_needed_next) begin
        a2 = (data_needed_next > 2'd1) ? v : '0;
        if (!delegated_mode) begin
          res.kind       = KIND_CHANNEL;
          res.msg_status = current_status_next;
          res.msg_data1  = first_data_next;
          res.msg_data2  = a2;
          if (current_status_next[7:4] == GRP_NOTE_OFF) begin
            res.note_action = NOTE_OFF;
          end else if (current_status_next[7:4] == GRP_NOTE_ON) begin
            res.note_action = (a2 != '0) ? NOTE_ON : NOTE_OFF;
          end
        end
        data_count_next     = '0;
        data_needed_next    = data_needed_for(running_status);
        current_status_next = running_status;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_sysex       <= 1'b0;
      current_status <= '0;
      running_status <= '0;
      data_count     <= '0;
      data_needed    <= '0;
      first_data     <= '0;
      sysex_count    <= '0;
    end else if (accept) begin
      in_sysex       <= in_sysex_next;
      current_status <= current_status_next;
      running_status <= running_status_next;
      data_count     <= data_count_next;
      data_needed    <= data_needed_next;
      first_data     <= first_data_next;
      sysex_count    <= sysex_count_next;
    end
  end

  // ---------------------------------------------------------------------------
  // result register plus one skid entry; skid always holds the younger beat
  // ---------------------------------------------------------------------------
  result_t out_reg;
  result_t skid_reg;
  logic    skid_valid;
  logic    out_take;

  assign out_take = out_valid && !out_stall;
  assign in_stall = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_take) begin
      out_reg <= skid_valid ? skid_reg : res;
    end
    if (out_valid && !out_take && accept) begin
      skid_reg <= res;
    end
  end

  assign kind         = out_reg.kind;
  assign msg_status   = out_reg.msg_status;
  assign msg_data1    = out_reg.msg_data1;
  assign msg_data2    = out_reg.msg_data2;
  assign note_action  = out_reg.note_action;
  assign sysex_byte   = out_reg.sysex_byte;
  assign sysex_length = out_reg.sysex_length;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  // skid only fills behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held with no result in the output register");

  // sysex count never passes the buffer limit
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    sysex_count <= SX_LIMIT)
    else $error("sysex count beyond buffer limit");

  // count only lives while a sysex is open
  a_count_idle: assert property (@(posedge clk) disable iff (rst)
    !in_sysex |-> sysex_count == '0)
    else $error("sysex count left over outside a sysex");

  // note classification only rides on channel messages
  a_note_kind: assert property (@(posedge clk) disable iff (rst)
    (out_valid && note_action != NOTE_NONE) |-> kind == KIND_CHANNEL)
    else $error("note action on a non-channel result");

  // a sysex start leaves the parser inside a sysex
  a_start_opens: assert property (@(posedge clk) disable iff (rst)
    (accept && res.kind == KIND_SX_START) |=> in_sysex)
    else $error("sysex start without entering sysex");

endmodule
